// File: design/epr_pkg.sv
// Package for the Euler point rotation block.
// Holds widths, payload and pipeline types, the CORDIC arctangent table and axis codes.
// No dependencies.
package epr_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int TRIG_FRAC  = ((60 - COORD_WIDTH) < 30) ? (60 - COORD_WIDTH) : 30;
  localparam int TRIG_W     = TRIG_FRAC + 2;
  localparam int TRIG_SHIFT = 30 - TRIG_FRAC;
  localparam int WORK_W     = COORD_WIDTH + 2;
  localparam int PROD_W     = WORK_W + TRIG_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int CXY_W      = 34;
  localparam int CZ_W       = 33;
  localparam int STEP_W     = 5;
  localparam int LATENCY    = CORDIC_STEPS + 8;

  localparam logic [CXY_W-1:0] CORDIC_GAIN = CXY_W'(32'h26DD3B6A);

  typedef enum logic [2:0] {
    AXIS_X = 3'b001,
    AXIS_Y = 3'b010,
    AXIS_Z = 3'b100
  } axis_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic [ANGLE_WIDTH-1:0]        angle_x;
    logic [ANGLE_WIDTH-1:0]        angle_y;
    logic [ANGLE_WIDTH-1:0]        angle_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;
  } out_t;

  typedef struct packed {
    logic signed [CXY_W-1:0] x;
    logic signed [CXY_W-1:0] y;
    logic signed [CZ_W-1:0]  z;
    logic                    flip;
  } lane_t;

  // CORDIC pipe word: three angle lanes plus the point riding alongside
  typedef struct packed {
    lane_t [2:0]                   lane;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic                          order;
  } cstg_t;

  // rotation pipe word, lanes indexed 0 = X, 1 = Y, 2 = Z
  typedef struct packed {
    logic signed [WORK_W-1:0] x;
    logic signed [WORK_W-1:0] y;
    logic signed [WORK_W-1:0] z;
    logic [2:0][TRIG_W-1:0]   c;
    logic [2:0][TRIG_W-1:0]   s;
    logic                     order;
  } rstg_t;

  function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // plane rotation axis for each of the three rotation cells
  function automatic axis_t rot_axis(input logic [1:0] idx, input logic order);
    axis_t a;
    case (idx)
      2'd0:    a = order ? AXIS_Z : AXIS_X;
      2'd1:    a = AXIS_Y;
      default: a = order ? AXIS_X : AXIS_Z;
    endcase
    return a;
  endfunction

endpackage

// File: design/epr_cordic_cell.sv
// One CORDIC micro-rotation step for three angle lanes, registered.
// Depends on epr_pkg.
module epr_cordic_cell import epr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [STEP_W-1:0] step_idx,
  input  logic              in_valid,
  input  cstg_t             in_stg,
  output logic              out_valid,
  output cstg_t             out_stg
);

  logic  valid_r;
  cstg_t stg_r;
  cstg_t stg_nxt;

  always_comb begin
    logic signed [CXY_W-1:0] x, y, dx, dy;
    logic signed [CZ_W-1:0]  z, at;
    stg_nxt = in_stg;
    at = $signed({1'b0, atan_turns(step_idx)});
    for (int k = 0; k < 3; k++) begin
      x  = in_stg.lane[k].x;
      y  = in_stg.lane[k].y;
      z  = in_stg.lane[k].z;
      dx = y >>> step_idx;
      dy = x >>> step_idx;
      if (!z[CZ_W-1]) begin
        stg_nxt.lane[k].x = x - dx;
        stg_nxt.lane[k].y = y + dy;
        stg_nxt.lane[k].z = z - at;
      end else begin
        stg_nxt.lane[k].x = x + dx;
        stg_nxt.lane[k].y = y - dy;
        stg_nxt.lane[k].z = z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    stg_r <= stg_nxt;
  end

  assign out_valid = valid_r;
  assign out_stg   = stg_r;

endmodule

// File: design/epr_rot_cell.sv
// One plane rotation: products registered, then summed and rounded back to coordinate scale (TRIG_FRAC bits dropped).
// Depends on epr_pkg.
module epr_rot_cell import epr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] rot_idx,
  input  logic       in_valid,
  input  rstg_t      in_stg,
  output logic       out_valid,
  output rstg_t      out_stg
);

  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (TRIG_FRAC - 1);

  logic                     valid_a_r, valid_b_r;
  rstg_t                    stg_a_r, stg_b_r, stg_b_nxt;
  axis_t                    ax_in, ax_a;
  logic signed [PROD_W-1:0] ac_r, bs_r, as_r, bc_r;
  logic signed [WORK_W-1:0] a_in, b_in;
  logic signed [TRIG_W-1:0] c_in, s_in;
  logic signed [SUM_W-1:0]  ra_sum, rb_sum;
  logic signed [WORK_W-1:0] ra, rb;

  assign ax_in = rot_axis(rot_idx, in_stg.order);
  assign ax_a  = rot_axis(rot_idx, stg_a_r.order);

  always_comb begin
    case (ax_in)
      AXIS_X: begin
        a_in = in_stg.y; b_in = in_stg.z;
        c_in = in_stg.c[0]; s_in = in_stg.s[0];
      end
      AXIS_Y: begin
        a_in = in_stg.z; b_in = in_stg.x;
        c_in = in_stg.c[1]; s_in = in_stg.s[1];
      end
      default: begin
        a_in = in_stg.x; b_in = in_stg.y;
        c_in = in_stg.c[2]; s_in = in_stg.s[2];
      end
    endcase
  end

  assign ra_sum = SUM_W'(ac_r) - SUM_W'(bs_r) + RND;
  assign rb_sum = SUM_W'(as_r) + SUM_W'(bc_r) + RND;
  assign ra     = WORK_W'(ra_sum >>> TRIG_FRAC);
  assign rb     = WORK_W'(rb_sum >>> TRIG_FRAC);

  always_comb begin
    stg_b_nxt = stg_a_r;
    case (ax_a)
      AXIS_X:  begin stg_b_nxt.y = ra; stg_b_nxt.z = rb; end
      AXIS_Y:  begin stg_b_nxt.z = ra; stg_b_nxt.x = rb; end
      default: begin stg_b_nxt.x = ra; stg_b_nxt.y = rb; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      valid_a_r <= in_valid;
      valid_b_r <= valid_a_r;
    end
    ac_r    <= PROD_W'(a_in * c_in);
    bs_r    <= PROD_W'(b_in * s_in);
    as_r    <= PROD_W'(a_in * s_in);
    bc_r    <= PROD_W'(b_in * c_in);
    stg_a_r <= in_stg;
    stg_b_r <= stg_b_nxt;
  end

  assign out_valid = valid_b_r;
  assign out_stg   = stg_b_r;

endmodule

// File: design/euler_point_rotation.sv
// Euler point rotation top level: CORDIC cell chain, trig rounding, three rotation cells,
// output clamp. Depends on epr_pkg, epr_cordic_cell, epr_rot_cell.
// Throughput: one point per cycle, set by the fully pipelined cell chain; busy stays low.
// Results cannot be stalled. Synchronous active-low reset clears the valid chain and
// order_r (object order).
module euler_point_rotation import epr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam int ASH = 32 - ANGLE_WIDTH;
  localparam logic signed [CXY_W:0] TRND =
    (TRIG_SHIFT > 0) ? ((CXY_W+1)'(1) <<< (TRIG_SHIFT - 1)) : '0;
  localparam logic signed [WORK_W-1:0] CMAX = WORK_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [WORK_W-1:0] CMIN = -CMAX - WORK_W'(1);

  logic  order_r;
  logic  accept;
  cstg_t c0;
  logic  cv  [CORDIC_STEPS+1];
  cstg_t cs  [CORDIC_STEPS+1];
  logic  tv_r;
  rstg_t ts_r, ts_nxt;
  logic  rv  [4];
  rstg_t rs  [4];
  logic  ov_r;
  out_t  od_r, od_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    logic [ANGLE_WIDTH-1:0] ang [3];
    logic [31:0]            a;
    logic                   fl;
    ang[0] = in_data.angle_x;
    ang[1] = in_data.angle_y;
    ang[2] = in_data.angle_z;
    c0.px    = in_data.point_x;
    c0.py    = in_data.point_y;
    c0.pz    = in_data.point_z;
    c0.order = order_r;
    for (int k = 0; k < 3; k++) begin
      a  = {ang[k], {ASH{1'b0}}};
      fl = a[31] ^ a[30];
      c0.lane[k].flip = fl;
      c0.lane[k].x    = CORDIC_GAIN;
      c0.lane[k].y    = '0;
      c0.lane[k].z    = CZ_W'($signed({a[31] ^ fl, a[30:0]}));
    end
  end

  assign cv[0] = accept;
  assign cs[0] = c0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    epr_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_idx  (STEP_W'(i)),
      .in_valid  (cv[i]),
      .in_stg    (cs[i]),
      .out_valid (cv[i+1]),
      .out_stg   (cs[i+1])
    );
  end

  // quadrant fix-up and rounding of cos/sin to TRIG_FRAC bits
  always_comb begin
    logic signed [CXY_W:0] xc, yc;
    cstg_t e;
    e = cs[CORDIC_STEPS];
    ts_nxt.x     = WORK_W'(e.px);
    ts_nxt.y     = WORK_W'(e.py);
    ts_nxt.z     = WORK_W'(e.pz);
    ts_nxt.order = e.order;
    for (int k = 0; k < 3; k++) begin
      xc = e.lane[k].flip ? -(CXY_W+1)'(e.lane[k].x) : (CXY_W+1)'(e.lane[k].x);
      yc = e.lane[k].flip ? -(CXY_W+1)'(e.lane[k].y) : (CXY_W+1)'(e.lane[k].y);
      ts_nxt.c[k] = TRIG_W'((xc + TRND) >>> TRIG_SHIFT);
      ts_nxt.s[k] = TRIG_W'((yc + TRND) >>> TRIG_SHIFT);
    end
  end

  assign rv[0] = tv_r;
  assign rs[0] = ts_r;

  for (genvar j = 0; j < 3; j++) begin : g_rot
    epr_rot_cell u_rot (
      .clk       (clk),
      .rst_n     (rst_n),
      .rot_idx   (2'(j)),
      .in_valid  (rv[j]),
      .in_stg    (rs[j]),
      .out_valid (rv[j+1]),
      .out_stg   (rs[j+1])
    );
  end

  always_comb begin
    logic signed [WORK_W-1:0] v [3];
    logic                     sat;
    v[0] = rs[3].x;
    v[1] = rs[3].y;
    v[2] = rs[3].z;
    sat  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (v[k] > CMAX) begin
        v[k] = CMAX; sat = 1'b1;
      end else if (v[k] < CMIN) begin
        v[k] = CMIN; sat = 1'b1;
      end
    end
    od_nxt.out_x     = COORD_WIDTH'(v[0]);
    od_nxt.out_y     = COORD_WIDTH'(v[1]);
    od_nxt.out_z     = COORD_WIDTH'(v[2]);
    od_nxt.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
      tv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
      tv_r <= cv[CORDIC_STEPS];
      ov_r <= rv[3];
    end
    ts_r <= ts_nxt;
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("transfer lost in pipeline");

  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without matching transfer");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.out_x == COORD_WIDTH'(CMAX) || out_data.out_x == COORD_WIDTH'(CMIN) ||
       out_data.out_y == COORD_WIDTH'(CMAX) || out_data.out_y == COORD_WIDTH'(CMIN) ||
       out_data.out_z == COORD_WIDTH'(CMAX) || out_data.out_z == COORD_WIDTH'(CMIN)))
    else $error("saturated flag without a clamped coordinate");

endmodule
